>>> hdl/closest_approach_golden_search_top_defines.svh
// ----------------------------------------------------------------------------
// Closest-approach golden search: assertion macros
// Shared concurrent-check forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_APPROACH_GOLDEN_SEARCH_TOP_DEFINES_SVH
`define CLOSEST_APPROACH_GOLDEN_SEARCH_TOP_DEFINES_SVH

// same-cycle implication
`define CAGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cags_pkg.sv
// ----------------------------------------------------------------------------
// Closest-approach golden search package
// Widths, fixed-point constants and defaults shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cags_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 65536;  // power of two
  localparam int unsigned DEF_MAX_PROBES  = 64;

  localparam int unsigned COORD_W = 36;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned EIDX_W  = 16;
  localparam int unsigned RANGE_W = 37;
  localparam int unsigned IW      = 20;   // signed probe index width
  localparam int unsigned MAG_W   = COORD_W + 1;
  localparam int unsigned SQ_W    = 76;   // sum of three squared magnitudes
  localparam int unsigned ROOT_W  = SQ_W / 2;

  localparam int unsigned ENTRY_W = TIME_W + 3 * COORD_W;

  localparam int unsigned S_TDATA_W = 224;
  localparam int unsigned M_TDATA_W = 104;

  // Q0.16 golden-section fractions
  localparam logic [15:0] GS_R   = 16'd40503;
  localparam logic [15:0] GS_C   = 16'd25035;
  localparam int          GS_TOL = 2;

  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

endpackage

>>> hdl/closest_approach_golden_search_top.sv
// ----------------------------------------------------------------------------
// Closest-approach golden search
// Trajectory sample table with a discrete golden-section nearest-point query.
// ----------------------------------------------------------------------------
// A write item (tuser = 0) stores one sample. A query item
// (tuser = 1) runs a golden-section search over the sample index and returns
// one item; the block takes no new item until the query has loaded its result
// into the output register. Each probe evaluation reads the table, forms the
// coordinate differences and builds the squared distance from nine partial
// products (three per coordinate) on a shared 19x19 multiplier; each search
// step passes through a loop test and two mixing states, and the query ends
// with the square root. TABLE_DEPTH must be a power of two; no clearing pass.
`timescale 1ns / 1ps

module closest_approach_golden_search_top #(
  parameter int unsigned TABLE_DEPTH = cags_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned MAX_PROBES  = cags_pkg::DEF_MAX_PROBES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, entry_time, coord_x, coord_y, coord_z,
  // lower_index, upper_index, middle_index, zero fill
  input  logic [cags_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // best_index, best_time, best_range, zero fill
  output logic [cags_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // probe_limit_hit
  output logic                            m_axis_tuser
);
  import cags_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned PCW   = $clog2(MAX_PROBES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_START, S_RD, S_DIFF, S_MUL, S_LOOP,
    S_MIX1, S_MIX2, S_PICK, S_PRD, S_PTIME, S_SQRT, S_OUT
  } state_e;

  state_e state_q;

  // input fields
  logic [EIDX_W-1:0]         in_eidx;
  logic [TIME_W-1:0]         in_time;
  logic signed [COORD_W-1:0] in_x, in_y, in_z;
  logic [EIDX_W-1:0]         in_lo, in_up, in_mid;

  assign in_eidx = s_axis_tdata[15:0];
  assign in_time = s_axis_tdata[63:16];
  assign in_x    = s_axis_tdata[99:64];
  assign in_y    = s_axis_tdata[135:100];
  assign in_z    = s_axis_tdata[171:136];
  assign in_lo   = s_axis_tdata[187:172];
  assign in_up   = s_axis_tdata[203:188];
  assign in_mid  = s_axis_tdata[219:204];

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // table memory
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic signed [IW-1:0] probe_q;

  assign ram_we    = accept && !s_axis_tuser &&
                     ({5'd0, in_eidx} < 21'(TABLE_DEPTH));
  assign ram_waddr = AW'(in_eidx);
  assign ram_wdata = {in_time, in_x, in_y, in_z};
  assign ram_raddr = AW'(probe_q);

  cags_ram #(
    .Width (ENTRY_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search registers
  logic signed [COORD_W-1:0] tgt_q [3];
  logic [EIDX_W-1:0]         ax_q, bx_q, cx_q;
  logic signed [IW-1:0]      x0_q, x1_q, x2_q, x3_q;
  logic [SQ_W-1:0]           f1_q, f2_q, acc_q;
  logic [MAG_W-1:0]          dmag_q [3];
  logic [1:0]                coord_q, part_q;
  logic                      which_q, init_q, dir_q, side_q, hit_q;
  logic [PCW-1:0]            probes_q;
  logic [15:0]               off_q;
  logic signed [IW+16:0]     pr_q;
  logic [TIME_W-1:0]         time_q;
  logic [EIDX_W-1:0]         bidx_q;
  logic [SQ_W-1:0]           sq_q;
  logic                      sq_start_q;

  // start offset
  logic [EIDX_W:0] dbc, dca, dsel;
  logic [31:0]     off_prod;
  always_comb begin
    dbc      = (bx_q >= cx_q) ? {1'b0, bx_q - cx_q} : {1'b0, cx_q - bx_q};
    dca      = (cx_q >= ax_q) ? {1'b0, cx_q - ax_q} : {1'b0, ax_q - cx_q};
    dsel     = (dbc > dca) ? dbc : dca;
    off_prod = {16'd0, GS_C} * {15'd0, dsel};
  end

  // squared distance, one partial product a cycle
  logic [MAG_W-1:0]   mag;
  logic [18:0]        mop_a, mop_b;
  logic [37:0]        mprod;
  logic [SQ_W-1:0]    mterm;
  always_comb begin
    mag   = dmag_q[coord_q];
    mop_a = mag[18:0];
    mop_b = mag[18:0];
    case (part_q)
      2'd1:    mop_a = {1'b0, mag[36:19]};
      2'd2: begin
        mop_a = {1'b0, mag[36:19]};
        mop_b = {1'b0, mag[36:19]};
      end
      default: ;
    endcase
    mprod = mop_a * mop_b;
    case (part_q)
      2'd1:    mterm = SQ_W'(mprod) << 20;
      2'd2:    mterm = SQ_W'(mprod) << 38;
      default: mterm = SQ_W'(mprod);
    endcase
  end

  // differences against the fetched sample
  logic signed [COORD_W-1:0] smp [3];
  logic signed [COORD_W:0]   sdiff [3];
  always_comb begin
    smp[0] = ram_rdata[3*COORD_W-1 -: COORD_W];
    smp[1] = ram_rdata[2*COORD_W-1 -: COORD_W];
    smp[2] = ram_rdata[COORD_W-1:0];
    for (int i = 0; i < 3; i++) begin
      sdiff[i] = {tgt_q[i][COORD_W-1], tgt_q[i]} - {smp[i][COORD_W-1], smp[i]};
    end
  end

  // new probe: (R*a + C*b) / 2^16, truncated toward zero
  logic signed [IW-1:0]  mix_a, mix_b, mix_res;
  logic signed [IW+17:0] mix_s, mix_neg;
  always_comb begin
    mix_a   = dir_q ? x3_q : x0_q;
    mix_b   = dir_q ? x1_q : x2_q;
    mix_s   = (IW+18)'(pr_q) +
              (IW+18)'($signed({1'b0, GS_C})) * (IW+18)'(mix_b);
    mix_neg = -mix_s;
    if (mix_s[IW+17]) begin
      mix_res = -IW'(mix_neg >>> 16);
    end else begin
      mix_res = IW'(mix_s >>> 16);
    end
  end

  // loop test and final pick
  logic signed [IW:0]   span;
  logic                 cont;
  logic                 f2_lt_f1, f1_lt_f2;
  logic signed [IW-1:0] pick, axs, bxs;
  logic signed [IW:0]   dpa, dpb;
  logic [EIDX_W-1:0]    clamp;
  always_comb begin
    span     = {x3_q[IW-1], x3_q} - {x0_q[IW-1], x0_q};
    cont     = (span > (IW+1)'(GS_TOL)) && (x2_q != x1_q);
    f2_lt_f1 = f2_q < f1_q;
    f1_lt_f2 = f1_q < f2_q;
    pick     = f1_lt_f2 ? x1_q : x2_q;
    axs      = IW'({1'b0, ax_q});
    bxs      = IW'({1'b0, bx_q});
    dpa      = {pick[IW-1], pick} - {axs[IW-1], axs};
    dpb      = {pick[IW-1], pick} - {bxs[IW-1], bxs};
    if (dpa[IW]) dpa = -dpa;
    if (dpb[IW]) dpb = -dpb;
    if (pick >= axs && pick <= bxs) begin
      clamp = pick[EIDX_W-1:0];
    end else begin
      clamp = (dpb > dpa) ? ax_q : bx_q;
    end
  end

  logic              sq_done;
  logic [RANGE_W-1:0] sq_root;

  cags_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start_q),
    .radicand_i (sq_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  logic                 m_valid_q, m_hit_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic                 out_load;
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      sq_start_q <= 1'b0;
      probes_q   <= '0;
      hit_q      <= 1'b0;
    end else begin
      sq_start_q <= (state_q == S_PTIME);
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && s_axis_tuser) begin
            tgt_q[0] <= in_x;
            tgt_q[1] <= in_y;
            tgt_q[2] <= in_z;
            ax_q     <= in_lo;
            bx_q     <= in_up;
            cx_q     <= in_mid;
            state_q  <= S_INIT;
          end
        end
        S_INIT: begin
          side_q  <= dbc > dca;
          off_q   <= off_prod[31:16];
          state_q <= S_START;
        end
        S_START: begin
          x0_q <= IW'({1'b0, ax_q});
          x3_q <= IW'({1'b0, bx_q});
          if (side_q) begin
            x1_q    <= IW'({1'b0, cx_q});
            x2_q    <= IW'({1'b0, cx_q}) + IW'({1'b0, off_q});
            probe_q <= IW'({1'b0, cx_q});
          end else begin
            x2_q    <= IW'({1'b0, cx_q});
            x1_q    <= IW'({1'b0, cx_q}) - IW'({1'b0, off_q});
            probe_q <= IW'({1'b0, cx_q}) - IW'({1'b0, off_q});
          end
          which_q  <= 1'b0;
          init_q   <= 1'b1;
          probes_q <= '0;
          hit_q    <= 1'b0;
          state_q  <= S_RD;
        end
        S_RD: begin
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            dmag_q[i] <= sdiff[i][COORD_W] ? MAG_W'(-sdiff[i]) : MAG_W'(sdiff[i]);
          end
          acc_q   <= '0;
          coord_q <= '0;
          part_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          acc_q <= acc_q + mterm;
          if (part_q == 2'd2) begin
            part_q  <= '0;
            coord_q <= coord_q + 1'b1;
          end else begin
            part_q <= part_q + 1'b1;
          end
          if (coord_q == 2'd2 && part_q == 2'd2) begin
            if (which_q) f2_q <= acc_q + mterm;
            else         f1_q <= acc_q + mterm;
            if (init_q && !which_q) begin
              probe_q <= x2_q;
              which_q <= 1'b1;
              state_q <= S_RD;
            end else begin
              init_q  <= 1'b0;
              state_q <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          if (!cont) begin
            state_q <= S_PICK;
          end else if (probes_q == PCW'(MAX_PROBES)) begin
            hit_q   <= 1'b1;
            state_q <= S_PICK;
          end else begin
            probes_q <= probes_q + 1'b1;
            dir_q    <= f2_lt_f1;
            if (f2_lt_f1) begin
              x0_q <= x1_q;
              x1_q <= x2_q;
              f1_q <= f2_q;
            end else begin
              x3_q <= x2_q;
              x2_q <= x1_q;
              f2_q <= f1_q;
            end
            state_q <= S_MIX1;
          end
        end
        S_MIX1: begin
          pr_q    <= $signed({1'b0, GS_R}) * mix_a;
          state_q <= S_MIX2;
        end
        S_MIX2: begin
          probe_q <= mix_res;
          if (dir_q) begin
            x2_q    <= mix_res;
            which_q <= 1'b1;
          end else begin
            x1_q    <= mix_res;
            which_q <= 1'b0;
          end
          state_q <= S_RD;
        end
        S_PICK: begin
          probe_q <= pick;
          sq_q    <= f1_lt_f2 ? f1_q : f2_q;
          bidx_q  <= clamp;
          state_q <= S_PRD;
        end
        S_PRD: begin
          state_q <= S_PTIME;
        end
        S_PTIME: begin
          time_q  <= ram_rdata[ENTRY_W-1 -: TIME_W];
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done && !sq_start_q) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_hit_q   <= hit_q;
            m_data_q  <= {3'd0, sq_root, time_q, bidx_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "closest_approach_golden_search_top_defines.svh"

  `CAGS_ASSERT_NOW(a_probe_bound, 1'b1, probes_q <= PCW'(MAX_PROBES), "probe count overran")
  `CAGS_ASSERT_NOW(a_hit_at_limit, out_load && hit_q, probes_q == PCW'(MAX_PROBES),
    "limit flag without full probe count")
  `CAGS_ASSERT_NEXT(a_query_blocks, accept && s_axis_tuser, !s_axis_tready,
    "input open during a query")

endmodule

>>> hdl/cags_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cags_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/cags_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Restoring digit-by-digit root, two radicand bits a cycle, saturated result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cags_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cags_pkg::SQ_W-1:0]     radicand_i,
  output logic                          done_o,
  output logic [cags_pkg::RANGE_W-1:0]  root_o
);
  import cags_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]    val_q, val_d;
  logic [ROOT_W+2:0]  rem_q, rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [ROOT_W+2:0]  shifted;
  logic [ROOT_W+2:0]  trial;

  always_comb begin
    val_d   = val_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_o  = 1'b0;
    shifted = {rem_q[ROOT_W:0], val_q[SQ_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    if (start_i) begin
      val_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[SQ_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
      end
    end else if (cnt_q == CNT_W'(ROOT_W)) begin
      done_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q[ROOT_W-1] ? RANGE_MAX : root_q[RANGE_W-1:0];

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Closest-approach golden search testbench
// Loads trajectory samples and runs nearest-point queries through the
// stream ports with random gaps and stalls on both sides. An internal model
// of the search predicts each result, and each output item is checked field
// by field. Queries are only sent once every table entry that the search
// would read has been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cags_pkg::*;

  localparam bit KIND_WRITE = 1'b0;
  localparam bit KIND_QUERY = 1'b1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET = 950;

  typedef struct {
    bit              kind;
    bit [15:0]       eidx;
    bit [TIME_W-1:0] etime;
    bit [COORD_W-1:0] x, y, z;
    bit [15:0]       lo, up, mid;
  } item_t;

  typedef struct {
    bit [15:0]        best_index;
    bit [TIME_W-1:0]  best_time;
    bit [RANGE_W-1:0] best_range;
    bit               limit_hit;
  } approach_t;

  class approach_scoreboard;
    bit [TIME_W-1:0] tm[65536];
    longint          px[65536], py[65536], pz[65536];
    bit              written[65536];
    int unsigned     missing[$];
    approach_t       pending[$];
    int              errors;

    function longint sx(bit [COORD_W-1:0] v);
      return longint'(signed'(v));
    endfunction

    function longint absd(longint a, longint b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function logic [127:0] dist_sq(longint tx, longint ty, longint tz, longint idx);
      int unsigned a;
      logic [127:0] dx, dy, dz;
      a = 32'(idx & 64'hFFFF);
      if (!written[a]) missing.push_back(a);
      dx = 128'(absd(tx, px[a]));
      dy = 128'(absd(ty, py[a]));
      dz = 128'(absd(tz, pz[a]));
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function longint golden_mix(longint a, longint b);
      longint s;
      s = 64'sd40503 * a + 64'sd25035 * b;
      if (s >= 0) return s >>> 16;
      return -((-s) >>> 16);
    endfunction

    function bit [RANGE_W-1:0] root_sat(logic [127:0] v);
      logic [127:0] r, t;
      r = '0;
      for (int b = 37; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= v) r = t;
      end
      if (r > 128'h1F_FFFF_FFFF) r = 128'h1F_FFFF_FFFF;
      return r[RANGE_W-1:0];
    endfunction

    // golden-section search; unwritten addresses it touches land in missing
    function approach_t search(item_t it);
      longint tx, ty, tz, ax, bx, cx, x0, x1, x2, x3, pick;
      logic [127:0] f1, f2, fb;
      int probes;
      approach_t r;
      tx = sx(it.x); ty = sx(it.y); tz = sx(it.z);
      ax = it.lo; bx = it.up; cx = it.mid;
      x0 = ax; x3 = bx;
      probes = 0;
      r.limit_hit = 0;
      if (absd(bx, cx) > absd(cx, ax)) begin
        x1 = cx;
        x2 = cx + ((64'd25035 * absd(bx, cx)) >> 16);
      end else begin
        x2 = cx;
        x1 = cx - ((64'd25035 * absd(cx, ax)) >> 16);
      end
      f1 = dist_sq(tx, ty, tz, x1);
      f2 = dist_sq(tx, ty, tz, x2);
      while ((x3 - x0) > GS_TOL && x2 != x1) begin
        if (probes == DEF_MAX_PROBES) begin
          r.limit_hit = 1;
          break;
        end
        probes++;
        if (f2 < f1) begin
          x0 = x1; x1 = x2; x2 = golden_mix(x3, x1);
          f1 = f2; f2 = dist_sq(tx, ty, tz, x2);
        end else begin
          x3 = x2; x2 = x1; x1 = golden_mix(x0, x2);
          f2 = f1; f1 = dist_sq(tx, ty, tz, x1);
        end
      end
      if (f1 < f2) begin
        pick = x1; fb = f1;
      end else begin
        pick = x2; fb = f2;
      end
      if (pick >= ax && pick <= bx) r.best_index = pick[15:0];
      else r.best_index = (absd(pick, bx) > absd(pick, ax)) ? ax[15:0] : bx[15:0];
      r.best_time  = tm[pick & 64'hFFFF];
      r.best_range = root_sat(fb);
      return r;
    endfunction

    function void note_item(item_t it);
      if (it.kind == KIND_WRITE) begin
        tm[it.eidx] = it.etime;
        px[it.eidx] = sx(it.x);
        py[it.eidx] = sx(it.y);
        pz[it.eidx] = sx(it.z);
        written[it.eidx] = 1;
      end else begin
        missing.delete();
        pending.push_back(search(it));
      end
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(approach_t got);
      approach_t w;
      if (pending.size() == 0) begin
        $display("[%0t] mismatch: result item with nothing pending", $realtime);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.best_index != w.best_index) report("best_index", got.best_index, w.best_index);
      if (got.best_time != w.best_time) report("best_time", got.best_time, w.best_time);
      if (got.best_range != w.best_range) report("best_range", got.best_range, w.best_range);
      if (got.limit_hit != w.limit_hit) report("probe_limit_hit", got.limit_hit, w.limit_hit);
    endtask
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  approach_scoreboard sb = new();
  bit  calm;          // stretch with no idling
  int  idle_cycles;
  int  n_sent;

  closest_approach_golden_search_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // caller is at a rising edge
  task automatic send(item_t it);
    int g;
    s_axis_tvalid <= 1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {4'd0, it.mid, it.up, it.lo, it.z, it.y, it.x, it.etime, it.eidx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    n_sent++;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic item_t rand_write(int unsigned idx);
    item_t it;
    it.kind  = KIND_WRITE;
    it.eidx  = 16'(idx);
    it.etime = 48'({$urandom, $urandom});
    it.x = 36'({$urandom, $urandom});
    it.y = 36'({$urandom, $urandom});
    it.z = 36'({$urandom, $urandom});
    if ($urandom_range(0, 2) != 0) begin
      // a smooth track makes the search meaningful
      it.x = 36'(idx * 1000 - 30000 + $urandom_range(0, 50));
      it.y = 36'(-idx * 700 + $urandom_range(0, 50));
      it.z = 36'(idx * 13);
    end
    it.lo = 16'($urandom); it.up = 16'($urandom); it.mid = 16'($urandom);
    return it;
  endfunction

  // fill every entry the search would read, then send the query
  task automatic query(item_t it);
    approach_t dummy;
    it.kind = KIND_QUERY;
    forever begin
      sb.missing.delete();
      dummy = sb.search(it);
      if (sb.missing.size() == 0) break;
      send(rand_write(sb.missing[0]));
    end
    send(it);
  endtask

  function automatic item_t mk_query(int lo, int up, int mid,
                                     bit [35:0] x, bit [35:0] y, bit [35:0] z);
    item_t it;
    it = rand_write($urandom_range(0, 65535));
    it.kind = KIND_QUERY;
    it.lo = 16'(lo); it.up = 16'(up); it.mid = 16'(mid);
    it.x = x; it.y = y; it.z = z;
    return it;
  endfunction

  // result side: random stalls, check at acceptance
  int stall;
  always @(posedge clk_i) begin
    approach_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.best_index = m_axis_tdata[15:0];
      got.best_time  = m_axis_tdata[63:16];
      got.best_range = m_axis_tdata[100:64];
      got.limit_hit  = m_axis_tuser;
      sb.check_result(got);
    end
    if (stall > 0) begin
      stall--;
      m_axis_tready <= 0;
    end else begin
      stall = gap_len();
      m_axis_tready <= rst_ni && (stall == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    item_t it;
    int r, lo, up, mid;
    idle_cycles = 0;
    n_sent = 0;
    calm = 0;
    stall = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // field extremes
    it = rand_write(0);
    it.etime = '1; it.x = 36'h800000000; it.y = 36'h7FFFFFFFF; it.z = '0;
    send(it);
    it = rand_write(65535);
    it.etime = '0; it.x = 36'h7FFFFFFFF; it.y = 36'h800000000; it.z = 36'h7FFFFFFFF;
    send(it);
    for (int i = 1; i <= 20; i++) send(rand_write(i));
    query(mk_query(0, 20, 10, 36'h800000000, 36'h800000000, 36'h800000000));
    query(mk_query(0, 20, 10, 36'h7FFFFFFFF, 36'h7FFFFFFFF, 36'h7FFFFFFFF));
    query(mk_query(5, 5, 5, 0, 0, 0));
    query(mk_query(1, 20, 1, 36'd5000, 0, 0));
    query(mk_query(1, 20, 20, 36'd5000, 0, 0));
    // inverted bracket
    query(mk_query(20, 2, 10, 0, 0, 0));
    // whole table
    query(mk_query(0, 65535, 32768, 36'd1234, 36'd99, 0));
    // equal distances everywhere in the bracket
    for (int i = 30; i <= 40; i++) begin
      it = rand_write(i);
      it.x = 36'd777; it.y = 36'd777; it.z = 36'd777;
      send(it);
    end
    query(mk_query(30, 40, 35, 0, 0, 0));

    for (int n = 0; n_sent < ITEM_TARGET; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send(rand_write(r < 40 ? $urandom_range(0, 255) : $urandom_range(0, 65535)));
      end else begin
        if (r < 85) begin
          lo = $urandom_range(0, 200);
          up = lo + $urandom_range(0, 55);
        end else if (r < 92) begin
          up = $urandom_range(0, 200);
          lo = up + $urandom_range(1, 40);
        end else begin
          lo = $urandom_range(0, 65535);
          up = $urandom_range(0, 65535);
        end
        mid = (lo <= up) ? $urandom_range(lo, up) : $urandom_range(up, lo);
        it = mk_query(lo, up, mid, 0, 0, 0);
        if ($urandom_range(0, 1)) begin
          it.x = 36'(lo * 1000 - 30000 + $urandom_range(0, 90000));
          it.y = 36'(-lo * 700 + $urandom_range(0, 20000));
          it.z = 36'($urandom_range(0, 3000));
        end else begin
          it.x = 36'({$urandom, $urandom});
          it.y = 36'({$urandom, $urandom});
          it.z = 36'({$urandom, $urandom});
        end
        query(it);
      end
    end
    s_axis_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> closest_approach_golden_search_top.f
+incdir+hdl
hdl/cags_pkg.sv
hdl/cags_ram.sv
hdl/cags_isqrt.sv
hdl/closest_approach_golden_search_top.sv
tb/tb.sv
